// ===== rtl/r2fft_pkg.sv =====
package r2fft_pkg;

    localparam int LOG2_PTS  = 8;
    localparam int NPTS      = 1 << LOG2_PTS;
    localparam int HALF_PTS  = NPTS >> 1;
    localparam int QUART_PTS = NPTS >> 2;
    localparam int ADDR_W    = LOG2_PTS;
    localparam int STAGE_W   = $clog2(LOG2_PTS);
    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 16;
    localparam int WORK_W    = 25;
    localparam int TW_W      = FRAC_BITS + 2;
    localparam int PROD_W    = WORK_W + TW_W;

    localparam real TW_ANG_STEP = 3.14159265358979323846 / real'(HALF_PTS);

    typedef logic signed [WORK_W-1:0] t_work;

    typedef struct packed {
        t_work re;
        t_work im;
    } t_cplx;

    typedef struct packed {
        logic mul_en;
        logic mul_imag;
        logic tr_en;
        logic ti_en;
    } t_bfly_ctl;

    typedef logic signed [TW_W-1:0] t_tw_tab [HALF_PTS];

    function automatic int tw_round(input real x);
        if (x >= 0.0) begin
            return $rtoi(x + 0.5);
        end
        return -$rtoi(-x + 0.5);
    endfunction

    function automatic t_tw_tab make_tw(input bit want_sin);
        t_tw_tab tab;
        real     sc;
        real     ang;
        sc   = real'(1 << FRAC_BITS);
        for (int i = 0; i < HALF_PTS; i++) begin
            if (i <= QUART_PTS) begin
                ang = TW_ANG_STEP * real'(i);
                tab[i] = want_sin ? TW_W'(-tw_round($sin(ang) * sc))
                                  : TW_W'(tw_round($cos(ang) * sc));
            end else begin
                ang = TW_ANG_STEP * real'(i - QUART_PTS);
                tab[i] = want_sin ? TW_W'(-tw_round($cos(ang) * sc))
                                  : TW_W'(-tw_round($sin(ang) * sc));
            end
        end
        return tab;
    endfunction

    localparam t_tw_tab TW_COS = make_tw(1'b0);
    localparam t_tw_tab TW_SIN = make_tw(1'b1);

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        for (int k = 0; k < ADDR_W; k++) begin
            r[k] = v[ADDR_W-1-k];
        end
        return r;
    endfunction

endpackage

// ===== rtl/r2fft_if.sv =====
interface r2fft_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] sample_re;
    logic [15:0] sample_im;

    modport source (output valid, req_type, sample_re, sample_im, input ready);
    modport sink   (input valid, req_type, sample_re, sample_im, output ready);
endinterface

interface r2fft_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] bin_re;
    logic [24:0] bin_im;
    logic [7:0]  bin_index;
    logic        last_bin;
    logic        result_valid;

    modport source (output valid, bin_re, bin_im, bin_index, last_bin, result_valid,
                    input ready);
    modport sink   (input valid, bin_re, bin_im, bin_index, last_bin, result_valid,
                    output ready);
endinterface

// ===== rtl/r2fft_ram.sv =====
module r2fft_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/r2fft_bfly.sv =====
module r2fft_bfly
    import r2fft_pkg::*;
(
    input  logic                   i_clk,
    input  t_bfly_ctl              i_ctl,
    input  t_cplx                  i_xa,
    input  t_cplx                  i_xb,
    input  logic signed [TW_W-1:0] i_wr,
    input  logic signed [TW_W-1:0] i_wi,
    output t_cplx                  o_sum,
    output t_cplx                  o_diff
);
    localparam logic signed [PROD_W:0] RND = (PROD_W+1)'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] n_p0;
    logic signed [PROD_W-1:0] n_p1;
    logic signed [PROD_W:0]   n_tr_full;
    logic signed [PROD_W:0]   n_ti_full;
    t_work                    r_tr;
    t_work                    r_ti;

    always_comb begin
        n_p0 = i_ctl.mul_imag ? i_wr * i_xb.im : i_wr * i_xb.re;
        n_p1 = i_ctl.mul_imag ? i_wi * i_xb.re : i_wi * i_xb.im;
        n_tr_full = $signed({r_p0[PROD_W-1], r_p0}) - $signed({r_p1[PROD_W-1], r_p1}) + RND;
        n_ti_full = $signed({r_p0[PROD_W-1], r_p0}) + $signed({r_p1[PROD_W-1], r_p1}) + RND;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
        end
        if (i_ctl.tr_en) begin
            r_tr <= n_tr_full[FRAC_BITS+WORK_W-1:FRAC_BITS];
        end
        if (i_ctl.ti_en) begin
            r_ti <= n_ti_full[FRAC_BITS+WORK_W-1:FRAC_BITS];
        end
    end

    assign o_sum.re  = i_xa.re + r_tr;
    assign o_sum.im  = i_xa.im + r_ti;
    assign o_diff.re = i_xa.re - r_tr;
    assign o_diff.im = i_xa.im - r_ti;
endmodule

// ===== rtl/radix2_dit_fft_256_unit.sv =====
// 256-point forward radix-2 decimation-in-time FFT with one shared butterfly unit.
// A load item (req_type 0) writes the next sample as it is taken; a read item
// (req_type 1) returns the next bin through an output register, which the read
// state loads once the register is free, with result_valid low and zero data
// until the first transform has finished. No item is taken in the read state.
// The 256th load starts the transform, during which no item is taken: the
// bit-reversal pass visits each index and swaps each pair by reading both
// words and writing them back, and the eight stages run one butterfly at a
// time, since the work memory has one read and one write port and each
// butterfly reads two words, runs two multiply rounds and writes two words.
module radix2_dit_fft_256_unit
    import r2fft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    r2fft_in_if.sink    i_req,
    r2fft_out_if.source o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD,
        S_P0, S_P1, S_P2, S_P3, S_P4,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7, S_B8
    } t_state;

    localparam logic [STAGE_W-1:0] STG_LAST = STAGE_W'(LOG2_PTS - 1);

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_lcnt;
    logic [ADDR_W-1:0]      r_rptr;
    logic [ADDR_W-1:0]      r_rd_k;
    logic                   r_done;
    logic [ADDR_W-1:0]      r_pi;
    logic [STAGE_W-1:0]     r_stage;
    logic [ADDR_W-2:0]      r_k;
    t_cplx                  r_xa;
    t_cplx                  r_xb;
    logic signed [TW_W-1:0] r_wr;
    logic signed [TW_W-1:0] r_wi;
    logic                   r_ov;
    t_work                  r_bin_re;
    t_work                  r_bin_im;
    logic [ADDR_W-1:0]      r_bin_idx;
    logic                   r_last;
    logic                   r_valid;

    logic                   acc;
    logic [ADDR_W-1:0]      pj;
    logic [ADDR_W-1:0]      low_mask;
    logic [ADDR_W-1:0]      kk;
    logic [ADDR_W-1:0]      ba;
    logic [ADDR_W-1:0]      bb;
    logic [ADDR_W-2:0]      tw_idx;
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    t_cplx                  wdata;
    t_cplx                  rdata;
    t_cplx                  ld_data;
    t_cplx                  sum;
    t_cplx                  diff;
    t_bfly_ctl              ctl;

    assign acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign pj       = bit_rev(r_pi);
    assign low_mask = ~({ADDR_W{1'b1}} << r_stage);
    assign kk       = {1'b0, r_k};
    assign ba       = ((kk & ~low_mask) << 1) | (kk & low_mask);
    assign bb       = ba | (ADDR_W'(1) << r_stage);
    assign tw_idx   = (r_k & low_mask[ADDR_W-2:0]) << (STG_LAST - r_stage);

    assign ld_data.re = {{(WORK_W-SAMPLE_W){i_req.sample_re[SAMPLE_W-1]}}, i_req.sample_re};
    assign ld_data.im = {{(WORK_W-SAMPLE_W){i_req.sample_im[SAMPLE_W-1]}}, i_req.sample_im};

    always_comb begin
        we    = 1'b0;
        waddr = r_pi;
        wdata = r_xa;
        raddr = r_rptr;
        unique case (r_state)
            S_IDLE: begin
                if (acc && !i_req.req_type) begin
                    we    = 1'b1;
                    waddr = r_lcnt;
                    wdata = ld_data;
                end
            end
            S_RD: raddr = r_rd_k;
            S_P0: raddr = r_pi;
            S_P1: raddr = pj;
            S_P2: raddr = pj;
            S_P3: begin
                we    = 1'b1;
                waddr = r_pi;
                wdata = rdata;
            end
            S_P4: begin
                we    = 1'b1;
                waddr = pj;
                wdata = r_xa;
            end
            S_B0: raddr = ba;
            S_B1: raddr = bb;
            S_B2, S_B3, S_B4, S_B5, S_B6: ;
            S_B7: begin
                we    = 1'b1;
                waddr = bb;
                wdata = diff;
            end
            S_B8: begin
                we    = 1'b1;
                waddr = ba;
                wdata = sum;
            end
        endcase
    end

    always_comb begin
        ctl.mul_en   = (r_state == S_B4) || (r_state == S_B5);
        ctl.mul_imag = (r_state == S_B5);
        ctl.tr_en    = (r_state == S_B5);
        ctl.ti_en    = (r_state == S_B6);
    end

    r2fft_ram #(
        .WIDTH ($bits(t_cplx)),
        .DEPTH (NPTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    r2fft_bfly u_bfly (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_xa   (r_xa),
        .i_xb   (r_xb),
        .i_wr   (r_wr),
        .i_wi   (r_wi),
        .o_sum  (sum),
        .o_diff (diff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lcnt  <= '0;
            r_rptr  <= '0;
            r_rd_k  <= '0;
            r_done  <= 1'b0;
            r_pi    <= '0;
            r_stage <= '0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && r_state != S_RD) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_req.req_type) begin
                            r_rd_k  <= r_rptr;
                            r_rptr  <= r_rptr + 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_lcnt <= r_lcnt + 1'b1;
                            if (r_lcnt == ADDR_W'(NPTS - 1)) begin
                                r_pi    <= '0;
                                r_state <= S_P0;
                            end
                        end
                    end
                end
                S_RD: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov      <= 1'b1;
                        r_bin_re  <= r_done ? rdata.re : '0;
                        r_bin_im  <= r_done ? rdata.im : '0;
                        r_bin_idx <= r_rd_k;
                        r_last    <= (r_rd_k == ADDR_W'(NPTS - 1));
                        r_valid   <= r_done;
                        r_state   <= S_IDLE;
                    end
                end
                S_P0: begin
                    if (pj > r_pi) begin
                        r_state <= S_P1;
                    end else if (r_pi == ADDR_W'(NPTS - 1)) begin
                        r_stage <= '0;
                        r_k     <= '0;
                        r_state <= S_B0;
                    end else begin
                        r_pi <= r_pi + 1'b1;
                    end
                end
                S_P1: begin
                    r_xa    <= rdata;
                    r_state <= S_P2;
                end
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_P4;
                S_P4: begin
                    r_pi    <= r_pi + 1'b1;
                    r_state <= S_P0;
                end
                S_B0: r_state <= S_B1;
                S_B1: begin
                    r_xa    <= rdata;
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_xb    <= rdata;
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_wr    <= TW_COS[tw_idx];
                    r_wi    <= TW_SIN[tw_idx];
                    r_state <= S_B4;
                end
                S_B4: r_state <= S_B5;
                S_B5: r_state <= S_B6;
                S_B6: r_state <= S_B7;
                S_B7: r_state <= S_B8;
                S_B8: begin
                    if (r_k == {(ADDR_W-1){1'b1}}) begin
                        r_k <= '0;
                        if (r_stage == STG_LAST) begin
                            r_done  <= 1'b1;
                            r_rptr  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_stage <= r_stage + 1'b1;
                            r_state <= S_B0;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_B0;
                    end
                end
            endcase
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.bin_re       = r_bin_re;
    assign o_res.bin_im       = r_bin_im;
    assign o_res.bin_index    = r_bin_idx;
    assign o_res.last_bin     = r_last;
    assign o_res.result_valid = r_valid;

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_RD))
        else $error("output loaded outside read state");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state == S_B8))
        else $error("transform done without last butterfly");

    a_rptr_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B8 && r_stage == STG_LAST && r_k == {(ADDR_W-1){1'b1}})
        |=> (r_rptr == '0 && r_state == S_IDLE))
        else $error("read pointer not cleared at transform end");
endmodule

// ===== test/radix2_dit_fft_256_unit_test.sv =====
module radix2_dit_fft_256_unit_test;
    import r2fft_pkg::*;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct {
        logic [24:0] bin_re;
        logic [24:0] bin_im;
        logic [7:0]  bin_index;
        logic        last_bin;
        logic        result_valid;
    } bin_t;

    class fft_scoreboard;
        longint acc_re [NPTS];
        longint acc_im [NPTS];
        longint cos_tab [HALF_PTS];
        longint sin_tab [HALF_PTS];
        int     load_cnt;
        int     read_ptr;
        bit     have_frame;
        bin_t   bins_due [$];
        int     errors;

        function new();
            real ang;
            real c;
            real s;
            for (int i = 0; i < HALF_PTS; i++) begin
                ang = -2.0 * 3.14159265358979323846 * real'(i) / real'(NPTS);
                c = $cos(ang) * 65536.0;
                s = $sin(ang) * 65536.0;
                cos_tab[i] = (c >= 0.0) ? $rtoi(c + 0.5) : -$rtoi(-c + 0.5);
                sin_tab[i] = (s >= 0.0) ? $rtoi(s + 0.5) : -$rtoi(-s + 0.5);
            end
            for (int i = 0; i < NPTS; i++) begin
                acc_re[i] = 0;
                acc_im[i] = 0;
            end
            load_cnt = 0;
            read_ptr = 0;
            have_frame = 0;
            errors = 0;
        endfunction

        function longint wrap25(longint v);
            logic signed [24:0] t;
            t = v[24:0];
            return longint'(t);
        endfunction

        function int rev8(int v);
            int r;
            r = 0;
            for (int k = 0; k < LOG2_PTS; k++) r = (r << 1) | ((v >> k) & 1);
            return r;
        endfunction

        function void transform();
            int     j;
            int     half;
            int     stride;
            int     a;
            int     b;
            longint t;
            longint tr;
            longint ti;
            for (int i = 0; i < NPTS; i++) begin
                j = rev8(i);
                if (j > i) begin
                    t = acc_re[i]; acc_re[i] = acc_re[j]; acc_re[j] = t;
                    t = acc_im[i]; acc_im[i] = acc_im[j]; acc_im[j] = t;
                end
            end
            for (int st = 1; st <= LOG2_PTS; st++) begin
                half = 1 << (st - 1);
                stride = NPTS / (2 * half);
                for (int g = 0; g < NPTS; g += 2 * half) begin
                    for (int p = 0; p < half; p++) begin
                        a = g + p;
                        b = a + half;
                        tr = (cos_tab[p*stride] * acc_re[b] - sin_tab[p*stride] * acc_im[b]
                              + 32768) >>> 16;
                        ti = (cos_tab[p*stride] * acc_im[b] + sin_tab[p*stride] * acc_re[b]
                              + 32768) >>> 16;
                        acc_re[b] = wrap25(acc_re[a] - tr);
                        acc_im[b] = wrap25(acc_im[a] - ti);
                        acc_re[a] = wrap25(acc_re[a] + tr);
                        acc_im[a] = wrap25(acc_im[a] + ti);
                    end
                end
            end
        endfunction

        function void note(logic req, logic [15:0] re, logic [15:0] im);
            bin_t e;
            if (req == REQ_LOAD) begin
                acc_re[load_cnt] = longint'($signed(re));
                acc_im[load_cnt] = longint'($signed(im));
                load_cnt = (load_cnt + 1) % NPTS;
                if (load_cnt == 0) begin
                    transform();
                    have_frame = 1;
                    read_ptr = 0;
                end
            end else begin
                e.bin_re = have_frame ? acc_re[read_ptr][24:0] : '0;
                e.bin_im = have_frame ? acc_im[read_ptr][24:0] : '0;
                e.bin_index = read_ptr[7:0];
                e.last_bin = (read_ptr == NPTS - 1);
                e.result_valid = have_frame;
                bins_due.push_back(e);
                read_ptr = (read_ptr + 1) % NPTS;
            end
        endfunction

        function void check(bin_t got);
            bin_t e;
            if (bins_due.size() == 0) begin
                $error("unexpected bin, index %0d", got.bin_index);
                errors++;
                return;
            end
            e = bins_due.pop_front();
            if (got.bin_re !== e.bin_re) begin
                $error("bin_re: expected %h, got %h", e.bin_re, got.bin_re);
                errors++;
            end
            if (got.bin_im !== e.bin_im) begin
                $error("bin_im: expected %h, got %h", e.bin_im, got.bin_im);
                errors++;
            end
            if (got.bin_index !== e.bin_index) begin
                $error("bin_index: expected %0d, got %0d", e.bin_index, got.bin_index);
                errors++;
            end
            if (got.last_bin !== e.last_bin) begin
                $error("last_bin: expected %b, got %b", e.last_bin, got.last_bin);
                errors++;
            end
            if (got.result_valid !== e.result_valid) begin
                $error("result_valid: expected %b, got %b", e.result_valid, got.result_valid);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    r2fft_in_if  req_if ();
    r2fft_out_if res_if ();

    radix2_dit_fft_256_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    fft_scoreboard fft_sb = new();
    bit            calm;
    int            stall_left = 0;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        bin_t got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.bin_re = res_if.bin_re;
            got.bin_im = res_if.bin_im;
            got.bin_index = res_if.bin_index;
            got.last_bin = res_if.last_bin;
            got.result_valid = res_if.result_valid;
            fft_sb.check(got);
        end
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic req, input logic [15:0] re, input logic [15:0] im);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= req;
        req_if.sample_re <= re;
        req_if.sample_im <= im;
        do @(posedge i_clk); while (!req_if.ready);
        fft_sb.note(req, re, im);
    endtask

    task automatic load_frame(input int count, input int read_odds, input bit corners);
        logic [15:0] re;
        logic [15:0] im;
        for (int k = 0; k < count; k++) begin
            re = 16'($urandom);
            im = 16'($urandom);
            if (corners && k < 16) begin
                re = k[0] ? 16'h7fff : 16'h8000;
                im = k[1] ? 16'h7fff : 16'h8000;
                if (k >= 8) im = 16'h0000;
            end
            send_item(REQ_LOAD, re, im);
            if (read_odds > 0 && $urandom_range(1, read_odds) == 1)
                send_item(REQ_READ, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fft_sb.bins_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.req_type <= REQ_LOAD;
        req_if.sample_re <= '0;
        req_if.sample_im <= '0;
        calm = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 4; k++) send_item(REQ_READ, 16'($urandom), 16'($urandom));
        load_frame(NPTS, 0, 1);
        for (int k = 0; k < 130; k++) send_item(REQ_READ, 16'($urandom), 16'($urandom));
        calm = 1;
        for (int k = 0; k < 126; k++) send_item(REQ_READ, 16'($urandom), 16'($urandom));
        calm = 0;
        drain();

        load_frame(60, 4, 0);
        for (int k = 0; k < 20; k++) send_item(REQ_READ, 16'($urandom), 16'($urandom));
        drain();
        repeat (20) @(posedge i_clk);
        if (fft_sb.errors == 0 && fft_sb.bins_due.size() == 0) begin
            $display("radix2_dit_fft_256_unit_test: clean");
        end else begin
            $display("radix2_dit_fft_256_unit_test: errors");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("radix2_dit_fft_256_unit_test: errors");
        $finish;
    end

endmodule
